// ----- design/usf_pkg.sv -----
package usf_pkg;

  localparam logic [7:0] AsciiLow    = 8'h20;
  localparam logic [7:0] Lead2Low    = 8'hC2;
  localparam logic [7:0] Lead2High   = 8'hDF;
  localparam logic [7:0] Lead3Low    = 8'hE0;
  localparam logic [7:0] Lead3High   = 8'hEF;
  localparam logic [7:0] Lead4Low    = 8'hF0;
  localparam logic [7:0] Lead4High   = 8'hF4;
  localparam logic [7:0] LeadE0      = 8'hE0;
  localparam logic [7:0] LeadED      = 8'hED;
  localparam logic [7:0] LeadEF      = 8'hEF;
  localparam logic [7:0] LeadF0      = 8'hF0;
  localparam logic [7:0] LeadF4      = 8'hF4;
  localparam logic [7:0] ContA0      = 8'hA0;
  localparam logic [7:0] Cont9F      = 8'h9F;
  localparam logic [7:0] ContBD      = 8'hBD;
  localparam logic [7:0] ContBF      = 8'hBF;
  localparam logic [7:0] Cont90      = 8'h90;
  localparam logic [7:0] Cont8F      = 8'h8F;
  localparam logic [1:0] ContTag     = 2'b10;

  // one request's worth of results: kept sequence bytes, then optional end marker
  typedef struct packed {
    logic [3:0][7:0] bytes;
    logic [2:0]      nbytes;
    logic            eos;
  } usf_job_t;

  typedef struct packed {
    logic full;
    logic empty;
  } usf_fifo_status_t;

endpackage

// ----- design/utf8_sanitize_filter.sv -----
// Strict UTF-8 filter: bytes enter on the input channel and only well-formed
// sequences (plus printable single bytes 20-7F) come out, each input request
// causing zero to five result requests; the end-of-string flag adds an end
// marker after any emitted bytes and discards an open sequence. A front end
// classifies one byte per clock and queues a job per byte that yields output;
// the back end drains jobs at one result per clock, when not stalled, through
// a registered output stage. Input is taken every cycle while the job queue
// (FifoDepth entries) has room, so sustained throughput is one input byte per
// clock when each byte yields at most one result, and otherwise is set by the
// back end at one result per clock.
module utf8_sanitize_filter #(
  parameter int unsigned FifoDepth = 4
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] in_byte_i,
  input  logic       end_of_string_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [7:0] out_byte_o,
  output logic       has_byte_o,
  output logic       string_end_o,
  output logic       last_in_run_o
);
  import usf_pkg::*;

  usf_job_t         push_job, head_job;
  usf_fifo_status_t fifo_status;
  logic             push, pop;

  assign in_stall_o = fifo_status.full;

  usf_front u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_byte_i       (in_byte_i),
    .end_of_string_i (end_of_string_i),
    .fifo_status_i   (fifo_status),
    .push_o          (push),
    .job_o           (push_job)
  );

  usf_fifo #(
    .Depth (FifoDepth)
  ) u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_job),
    .pop_i       (pop),
    .head_o      (head_job),
    .status_o    (fifo_status)
  );

  usf_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .head_i        (head_job),
    .fifo_status_i (fifo_status),
    .pop_o         (pop),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .out_byte_o    (out_byte_o),
    .has_byte_o    (has_byte_o),
    .string_end_o  (string_end_o),
    .last_in_run_o (last_in_run_o)
  );

endmodule

// ----- design/usf_front.sv -----
module usf_front (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  input  logic [7:0]               in_byte_i,
  input  logic                     end_of_string_i,
  input  usf_pkg::usf_fifo_status_t fifo_status_i,
  output logic                     push_o,
  output usf_pkg::usf_job_t        job_o
);
  import usf_pkg::*;

  logic [2:0][7:0] pend_q, pend_d;
  logic [1:0]      cnt_q, cnt_d;
  logic [1:0]      need_q, need_d;
  logic            accept;
  logic            is_cont;
  logic            bad3, bad4;
  logic [7:0]      b;

  assign b       = in_byte_i;
  assign accept  = in_valid_i && !fifo_status_i.full;
  assign is_cont = (b[7:6] == ContTag);

  assign bad3 = (cnt_q == 2'd2) &&
                (((pend_q[0] == LeadE0) && (pend_q[1] < ContA0)) ||
                 ((pend_q[0] == LeadED) && (pend_q[1] > Cont9F)) ||
                 ((pend_q[0] == LeadEF) && (pend_q[1] == ContBF) && (b > ContBD)));
  assign bad4 = (cnt_q == 2'd3) &&
                (((pend_q[0] == LeadF0) && (pend_q[1] < Cont90)) ||
                 ((pend_q[0] == LeadF4) && (pend_q[1] > Cont8F)));

  always_comb begin
    pend_d       = pend_q;
    cnt_d        = cnt_q;
    need_d       = need_q;
    job_o.bytes  = '0;
    job_o.nbytes = 3'd0;
    job_o.eos    = end_of_string_i;
    if ((need_q != 2'd0) && is_cont) begin
      if (need_q == 2'd1) begin
        job_o.bytes[0] = pend_q[0];
        job_o.bytes[1] = (cnt_q == 2'd1) ? b : pend_q[1];
        job_o.bytes[2] = (cnt_q == 2'd2) ? b : pend_q[2];
        job_o.bytes[3] = b;
        if (!bad3 && !bad4) begin
          job_o.nbytes = {1'b0, cnt_q} + 3'd1;
        end
        cnt_d  = 2'd0;
        need_d = 2'd0;
      end else begin
        if (cnt_q != 2'd3) begin
          pend_d[cnt_q] = b;
          cnt_d         = cnt_q + 2'd1;
        end
        need_d = need_q - 2'd1;
      end
    end else begin
      cnt_d  = 2'd0;
      need_d = 2'd0;
      if (!b[7] && (b >= AsciiLow)) begin
        job_o.bytes[0] = b;
        job_o.nbytes   = 3'd1;
      end else if ((b >= Lead2Low) && (b <= Lead2High)) begin
        pend_d[0] = b;
        cnt_d     = 2'd1;
        need_d    = 2'd1;
      end else if ((b >= Lead3Low) && (b <= Lead3High)) begin
        pend_d[0] = b;
        cnt_d     = 2'd1;
        need_d    = 2'd2;
      end else if ((b >= Lead4Low) && (b <= Lead4High)) begin
        pend_d[0] = b;
        cnt_d     = 2'd1;
        need_d    = 2'd3;
      end
    end
    if (end_of_string_i) begin
      cnt_d  = 2'd0;
      need_d = 2'd0;
    end
  end

  assign push_o = accept && ((job_o.nbytes != 3'd0) || job_o.eos);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= 2'd0;
      need_q <= 2'd0;
    end else if (accept) begin
      cnt_q  <= cnt_d;
      need_q <= need_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      pend_q <= pend_d;
    end
  end

endmodule

// ----- design/usf_fifo.sv -----
module usf_fifo #(
  parameter int unsigned Depth = 4
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      push_i,
  input  usf_pkg::usf_job_t         push_data_i,
  input  logic                      pop_i,
  output usf_pkg::usf_job_t         head_o,
  output usf_pkg::usf_fifo_status_t status_o
);
  import usf_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  usf_job_t        mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] cnt_q;
  logic            do_push, do_pop;

  assign status_o.full  = (cnt_q == CntW'(Depth));
  assign status_o.empty = (cnt_q == '0);
  assign do_push = push_i && !status_o.full;
  assign do_pop  = pop_i && !status_o.empty;
  assign head_o  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + CntW'(1);
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - CntW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

// ----- design/usf_back.sv -----
module usf_back (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  usf_pkg::usf_job_t         head_i,
  input  usf_pkg::usf_fifo_status_t fifo_status_i,
  output logic                      pop_o,
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output logic [7:0]                out_byte_o,
  output logic                      has_byte_o,
  output logic                      string_end_o,
  output logic                      last_in_run_o
);
  import usf_pkg::*;

  logic [2:0] idx_q;
  logic [2:0] total;
  logic       last;
  logic       load;
  logic       is_data;
  logic       out_valid_q;
  logic [7:0] byte_q;
  logic       has_q, end_q, last_q;

  assign total   = head_i.nbytes + {2'b00, head_i.eos};
  assign last    = (idx_q == (total - 3'd1));
  assign is_data = (idx_q < head_i.nbytes);
  assign load    = !fifo_status_i.empty && (!out_valid_q || !out_stall_i);
  assign pop_o   = load && last;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q       <= 3'd0;
      out_valid_q <= 1'b0;
    end else begin
      if (load) begin
        idx_q       <= last ? 3'd0 : idx_q + 3'd1;
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      byte_q <= is_data ? head_i.bytes[idx_q[1:0]] : 8'd0;
      has_q  <= is_data;
      end_q  <= !is_data;
      last_q <= last;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign out_byte_o    = byte_q;
  assign has_byte_o    = has_q;
  assign string_end_o  = end_q;
  assign last_in_run_o = last_q;

endmodule

// ----- design/usf_checker.sv -----
module usf_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_stall_o,
  input logic [7:0] in_byte_i,
  input logic       end_of_string_i,
  input logic       out_valid_o,
  input logic       out_stall_i,
  input logic [7:0] out_byte_o,
  input logic       has_byte_o,
  input logic       string_end_o,
  input logic       last_in_run_o
);

  // a result carries either a byte or the end marker
  a_kind_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (has_byte_o != string_end_o))
    else $error("result is neither pure byte nor pure end marker");

  // end marker closes the run of its request
  a_end_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && string_end_o) |-> last_in_run_o)
    else $error("end marker not last in run");

  a_marker_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !has_byte_o) |-> (out_byte_o == 8'd0))
    else $error("end marker carries nonzero byte");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=>
      (out_valid_o && $stable(out_byte_o) && $stable(has_byte_o) &&
       $stable(string_end_o) && $stable(last_in_run_o)))
    else $error("stalled result changed");

  // stalled input request keeps its payload
  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_stall_o) |=>
      (in_valid_i && $stable(in_byte_i) && $stable(end_of_string_i)))
    else $error("stalled input request changed");

endmodule

bind utf8_sanitize_filter usf_checker u_usf_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .in_valid_i      (in_valid_i),
  .in_stall_o      (in_stall_o),
  .in_byte_i       (in_byte_i),
  .end_of_string_i (end_of_string_i),
  .out_valid_o     (out_valid_o),
  .out_stall_i     (out_stall_i),
  .out_byte_o      (out_byte_o),
  .has_byte_o      (has_byte_o),
  .string_end_o    (string_end_o),
  .last_in_run_o   (last_in_run_o)
);

// ----- verif/testbench.sv -----
module testbench;
  import usf_pkg::*;

  localparam int ClkHalf = 6;
  localparam int ResetCycles = 11;
  localparam int DrainCycles = 8;
  localparam int IdleLimit = 2000;
  localparam int MaxReports = 30;
  localparam logic [7:0] ContEdges [8] =
    '{8'h80, Cont8F, Cont90, Cont9F, ContA0, ContBD, 8'hBE, ContBF};

  typedef struct packed {
    logic [7:0] out_byte;
    logic       has_byte;
    logic       string_end;
    logic       last_in_run;
  } usf_result_t;

  typedef enum logic [1:0] {
    RxFree,
    RxRandom,
    RxPattern
  } rx_mode_e;

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       in_valid_i = 1'b0;
  logic [7:0] in_byte_i = 8'h00;
  logic       end_of_string_i = 1'b0;
  logic       out_stall_i = 1'b0;
  logic       in_stall_o;
  logic       out_valid_o;
  logic [7:0] out_byte_o;
  logic       has_byte_o;
  logic       string_end_o;
  logic       last_in_run_o;

  // filter state as seen by the predictor
  logic [7:0] seq_bytes [3];
  logic [1:0] seq_len = 2'd0;
  logic [1:0] cont_left = 2'd0;

  usf_result_t filtered_q [$];
  int          errors = 0;
  int          busy_items = 0;
  int          burst_left = 0;
  bit          tx_bursty = 1'b1;
  rx_mode_e    rx_mode = RxRandom;
  int          hold_req = 0;

  utf8_sanitize_filter i_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .in_byte_i      (in_byte_i),
    .end_of_string_i(end_of_string_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .out_byte_o     (out_byte_o),
    .has_byte_o     (has_byte_o),
    .string_end_o   (string_end_o),
    .last_in_run_o  (last_in_run_o)
  );

  initial begin
    forever begin
      #ClkHalf clk_i = ~clk_i;
    end
  end

  // expected results of one accepted byte, appended to filtered_q
  function automatic int filter_byte(logic [7:0] b, logic eos);
    usf_result_t     res [5];
    logic [3:0][7:0] seq;
    int              n;
    int              len;
    int              i;
    bit              ok;
    n = 0;
    seq = '0;
    if (cont_left != 2'd0 && b[7:6] == ContTag) begin
      if (cont_left == 2'd1) begin
        len = int'(seq_len);
        for (i = 0; i < len; i++) seq[i] = seq_bytes[i];
        seq[len] = b;
        len++;
        ok = 1'b1;
        if (len == 3) begin
          if (seq[0] == LeadE0 && seq[1] < ContA0) ok = 1'b0;
          if (seq[0] == LeadED && seq[1] > Cont9F) ok = 1'b0;
          if (seq[0] == LeadEF && seq[1] == ContBF && seq[2] > ContBD) ok = 1'b0;
        end else if (len == 4) begin
          if (seq[0] == LeadF0 && seq[1] < Cont90) ok = 1'b0;
          if (seq[0] == LeadF4 && seq[1] > Cont8F) ok = 1'b0;
        end
        if (ok) begin
          for (i = 0; i < len; i++) begin
            res[n] = '{seq[i], 1'b1, 1'b0, 1'b0};
            n++;
          end
        end
        seq_len = 2'd0;
        cont_left = 2'd0;
      end else begin
        if (seq_len < 2'd3) begin
          seq_bytes[seq_len] = b;
          seq_len++;
        end
        cont_left--;
      end
    end else begin
      seq_len = 2'd0;
      cont_left = 2'd0;
      if (!b[7] && b >= AsciiLow) begin
        res[n] = '{b, 1'b1, 1'b0, 1'b0};
        n++;
      end else if (b >= Lead2Low && b <= Lead2High) begin
        seq_bytes[0] = b;
        seq_len = 2'd1;
        cont_left = 2'd1;
      end else if (b >= Lead3Low && b <= Lead3High) begin
        seq_bytes[0] = b;
        seq_len = 2'd1;
        cont_left = 2'd2;
      end else if (b >= Lead4Low && b <= Lead4High) begin
        seq_bytes[0] = b;
        seq_len = 2'd1;
        cont_left = 2'd3;
      end
    end
    if (eos) begin
      seq_len = 2'd0;
      cont_left = 2'd0;
      res[n] = '{8'h00, 1'b0, 1'b1, 1'b0};
      n++;
    end
    if (n > 0) res[n-1].last_in_run = 1'b1;
    for (i = 0; i < n; i++) filtered_q.insert(filtered_q.size(), res[i]);
    return n;
  endfunction

  // one request on the input channel, called at a falling edge
  task automatic send_byte(logic [7:0] b, logic eos);
    int n;
    if (tx_bursty && burst_left == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk_i);
      burst_left = $urandom_range(1, 10);
    end
    if (burst_left > 0) burst_left--;
    in_valid_i <= 1'b1;
    in_byte_i <= b;
    end_of_string_i <= eos;
    do @(posedge clk_i); while (in_stall_o);
    n = filter_byte(b, eos);
    if (n > 0 || cont_left != 2'd0) busy_items++;
    @(negedge clk_i);
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (filtered_q.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(negedge clk_i);
  endtask

  function automatic logic rand_eos();
    return ($urandom_range(0, 15) == 0);
  endfunction

  function automatic logic [7:0] pick_cont();
    if ($urandom_range(0, 2) == 0) return ContEdges[$urandom_range(0, 7)];
    return {ContTag, 6'($urandom_range(0, 63))};
  endfunction

  function automatic logic [7:0] pick_lead(int len);
    case (len)
      1: return 8'($urandom_range(AsciiLow, 8'h7F));
      2: return 8'($urandom_range(Lead2Low, Lead2High));
      3: begin
        case ($urandom_range(0, 3))
          0: return LeadE0;
          1: return LeadED;
          2: return LeadEF;
          default: return 8'($urandom_range(Lead3Low, Lead3High));
        endcase
      end
      default: begin
        case ($urandom_range(0, 2))
          0: return LeadF0;
          1: return LeadF4;
          default: return 8'($urandom_range(Lead4Low, Lead4High));
        endcase
      end
    endcase
  endfunction

  // lead plus continuations, sometimes cut short
  task automatic send_seq(int len);
    logic [7:0] lead;
    int         ncont;
    int         k;
    lead = pick_lead(len);
    ncont = len - 1;
    if (ncont > 0 && $urandom_range(0, 6) == 0) ncont = $urandom_range(0, ncont - 1);
    send_byte(lead, rand_eos());
    for (k = 0; k < ncont; k++) begin
      if (k == 0 && lead == LeadEF && $urandom_range(0, 1) == 1) begin
        send_byte(ContBF, rand_eos());
      end else begin
        send_byte(pick_cont(), rand_eos());
      end
    end
  endtask

  task automatic test_single_bytes();
    send_byte(8'h00, 1'b0);
    send_byte(8'h1F, 1'b0);
    send_byte(8'h7F, 1'b0);
    send_byte(8'h20, 1'b1);
    send_byte(8'hBF, 1'b0);
    send_byte(8'hC1, 1'b0);
    send_byte(8'hF5, 1'b0);
    send_byte(8'hFF, 1'b1);
  endtask

  task automatic test_well_formed();
    send_byte(Lead2Low, 1'b0);
    send_byte(8'h80, 1'b0);
    send_byte(LeadF4, 1'b0);
    send_byte(Cont8F, 1'b0);
    send_byte(ContBF, 1'b0);
    send_byte(ContBF, 1'b1);
  endtask

  task automatic test_ill_formed();
    send_byte(LeadED, 1'b0);
    send_byte(ContA0, 1'b0);
    send_byte(8'h80, 1'b0);
    send_byte(LeadF0, 1'b0);
    send_byte(Cont8F, 1'b0);
    send_byte(ContBF, 1'b0);
    send_byte(ContBF, 1'b0);
  endtask

  task automatic test_cut_short();
    send_byte(8'hE2, 1'b0);
    send_byte(8'h82, 1'b0);
    send_byte(8'h41, 1'b0);
    send_byte(8'hE2, 1'b1);
    wait_drained();
  endtask

  // output held off while the sender keeps offering four-byte sequences
  task automatic test_backpressure();
    tx_bursty = 1'b0;
    rx_mode = RxFree;
    hold_req = 80;
    @(negedge clk_i);
    repeat (10) send_seq(4);
    wait_drained();
  endtask

  task automatic test_random_text();
    int phase;
    int target;
    for (phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin
          rx_mode = RxFree;
          tx_bursty = 1'b0;
        end
        1: begin
          rx_mode = RxRandom;
          tx_bursty = 1'b1;
        end
        2: begin
          rx_mode = RxPattern;
          tx_bursty = 1'b1;
        end
        default: begin
          rx_mode = RxRandom;
          tx_bursty = 1'b0;
        end
      endcase
      target = busy_items + 45;
      while (busy_items < target) begin
        if ($urandom_range(0, 4) == 0) send_byte(8'($urandom), rand_eos());
        else send_seq($urandom_range(1, 4));
      end
      wait_drained();
    end
  endtask

  // receiver stall pattern
  initial begin
    int hold_left;
    int phase_cnt;
    hold_left = 0;
    phase_cnt = 0;
    forever begin
      @(negedge clk_i);
      phase_cnt++;
      if (hold_req > 0) begin
        hold_left = hold_req;
        hold_req = 0;
      end
      if (hold_left > 0) begin
        out_stall_i <= 1'b1;
        hold_left--;
      end else begin
        case (rx_mode)
          RxRandom: out_stall_i <= ($urandom_range(0, 99) < 35);
          RxPattern: out_stall_i <= ((phase_cnt % 7) < 3);
          default: out_stall_i <= 1'b0;
        endcase
      end
    end
  end

  task automatic check_field(string field, int want, int got);
    if (want != got) begin
      errors++;
      if (errors <= MaxReports) begin
        $display("%0t: %s mismatch, expected %0h, got %0h", $time, field, want, got);
      end
    end
  endtask

  // result checker
  initial begin
    usf_result_t want;
    forever begin
      @(posedge clk_i);
      if (rst_ni && out_valid_o && !out_stall_i) begin
        if (filtered_q.size() == 0) begin
          errors++;
          if (errors <= MaxReports) begin
            $display("%0t: unexpected request, expected none, got byte %0h end %0b",
                     $time, out_byte_o, string_end_o);
          end
        end else begin
          want = filtered_q.pop_front();
          check_field("out_byte", want.out_byte, out_byte_o);
          check_field("has_byte", want.has_byte, has_byte_o);
          check_field("string_end", want.string_end, string_end_o);
          check_field("last_in_run", want.last_in_run, last_in_run_o);
        end
      end
    end
  end

  // watchdog on cycles without any accepted request
  initial begin
    int idle_cycles;
    idle_cycles = 0;
    forever begin
      @(posedge clk_i);
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= IdleLimit) begin
        $display("testbench: errors");
        $finish;
      end
    end
  end

  initial begin
    repeat (ResetCycles) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    test_single_bytes();
    test_well_formed();
    test_ill_formed();
    test_cut_short();
    test_backpressure();
    test_random_text();
    wait_drained();
    if (errors == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

endmodule

// ----- files.f -----
design/usf_pkg.sv
design/usf_front.sv
design/usf_fifo.sv
design/usf_back.sv
design/utf8_sanitize_filter.sv
design/usf_checker.sv
verif/testbench.sv
